>>> hw/rtl/fcull_pkg.sv
// Frustum cull test unit: shared command codes, classification codes and queue item type.
// No dependencies.
package fcull_pkg;

   localparam logic [2:0] CMD_LOAD     = 3'd0;
   localparam logic [2:0] CMD_POINT    = 3'd1;
   localparam logic [2:0] CMD_SPH_CLS  = 3'd2;
   localparam logic [2:0] CMD_SPH_DIST = 3'd3;
   localparam logic [2:0] CMD_BOX_ANY  = 3'd4;
   localparam logic [2:0] CMD_BOX_CLS  = 3'd5;

   localparam logic [1:0] CLS_OUTSIDE   = 2'd0;
   localparam logic [1:0] CLS_INTERSECT = 2'd1;
   localparam logic [1:0] CLS_INSIDE    = 2'd2;

   localparam int REQ_DATA_BITS = 264;
   localparam int RSP_DATA_BITS = 40;

   typedef struct packed {
      logic [2:0]         command;
      logic [2:0]         plane_index;
      logic [1:0]         coefficient_index;
      logic signed [31:0] coefficient_value;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        sphere_radius;
      logic [30:0]        half_x;
      logic [30:0]        half_y;
      logic [30:0]        half_z;
   } item_type;

endpackage

>>> hw/rtl/fcull_front.sv
// Frustum cull front end: accepts requests, drops ignored ones, queues the rest.
// Depends on fcull_pkg.
module fcull_front
   import fcull_pkg::*;
#(
   parameter int PLANE_COUNT = 6
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep, push;

   assign in_ready = (count_ff != 2'd2);
   assign keep = (in_item.command <= CMD_BOX_CLS) &&
                 ((in_item.command != CMD_LOAD) ||
                  ({29'd0, in_item.plane_index} < PLANE_COUNT));
   assign push = in_valid && in_ready && keep;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> hw/rtl/fcull_back.sv
// Frustum cull back end: plane store, per-plane distance pipeline, result register.
// Depends on fcull_pkg.
module fcull_back
   import fcull_pkg::*;
#(
   parameter int PLANE_COUNT = 6,
   parameter int COORD_BITS  = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_classification,
   output logic               rsp_inside_flag,
   output logic signed [31:0] rsp_distance
);

   localparam int CB  = COORD_BITS;
   localparam int EW  = ((CB > 34) ? CB : 34) + 1;
   localparam int PRW = 32 + CB;
   localparam int XW  = (PRW > 64) ? PRW : 64;
   localparam int PIW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int CW  = $clog2(PLANE_COUNT + 1);
   localparam logic signed [EW-1:0] CMAX = (EW'(1) <<< (CB - 1)) - EW'(1);
   localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);
   localparam logic signed [XW-1:0] TLIM = XW'(64'h2000_0000_0000_0000);
   localparam logic signed [XW-1:0] TNEG = -TLIM;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   function automatic logic signed [CB-1:0] sat_c(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
      return r[CB-1:0];
   endfunction

   function automatic logic signed [63:0] term(input logic signed [PRW-1:0] p);
      logic signed [XW-1:0] s;
      s = XW'(p);
      s = s >>> FRAC_BITS;
      if (s > TLIM) s = TLIM;
      if (s < TNEG) s = TNEG;
      return s[63:0];
   endfunction

   logic [31:0] store_ff [PLANE_COUNT][4];

   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        v1_ff, v2_ff, v3_ff;
   logic [2:0]  cmd_ff;
   logic [30:0] rad_ff;
   logic signed [CB-1:0] crd_ff [6];

   logic signed [PRW-1:0] prod_ff [6];
   logic signed [31:0]    d1_ff, d2_ff;
   logic signed [63:0]    t_ff [6];
   logic signed [63:0]    s_ff [8];

   logic        any_neg_ff, sph_out_ff, box_out_ff;
   logic [CW-1:0] above_ff, full_ff;
   logic signed [63:0] last_d_ff;

   logic        rsp_valid_ff;
   logic [1:0]  cls_ff;
   logic        flag_ff;
   logic signed [31:0] dist_ff;

   logic        issue, start, is_box, fire;
   logic [PIW-1:0] ridx;
   logic signed [63:0] rr, d0;
   logic [3:0]  npos;
   logic signed [64:0] dsum;
   logic signed [31:0] dsat;
   logic [1:0]  cls_v;
   logic        flag_v;
   logic signed [31:0] dist_v;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_classification = cls_ff;
   assign rsp_inside_flag = flag_ff;
   assign rsp_distance = dist_ff;

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign start = q_pop && (q_item.command != CMD_LOAD);
   assign issue = (state_ff == ST_RUN) && ({{(32-CW){1'b0}}, cnt_ff} < PLANE_COUNT);
   assign ridx = cnt_ff[PIW-1:0];
   assign is_box = (q_item.command == CMD_BOX_ANY) || (q_item.command == CMD_BOX_CLS);
   assign fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rr = $signed({33'd0, rad_ff});
   assign d0 = s_ff[0];

   always_comb begin
      npos = 4'd0;
      for (int k = 0; k < 8; k++) begin
         npos = npos + {3'd0, (s_ff[k] > 64'sd0)};
      end
      dsum = 65'(last_d_ff) + 65'(rr);
      if (dsum > 65'sd2147483647) dsat = 32'h7FFF_FFFF;
      else if (dsum < -65'sd2147483648) dsat = 32'h8000_0000;
      else dsat = dsum[31:0];
      cls_v = CLS_OUTSIDE;
      flag_v = 1'b0;
      dist_v = 32'sd0;
      case (cmd_ff)
         CMD_POINT: begin
            flag_v = !any_neg_ff;
         end
         CMD_SPH_CLS: begin
            cls_v = sph_out_ff ? CLS_OUTSIDE :
                    ((above_ff == CW'(PLANE_COUNT)) ? CLS_INSIDE : CLS_INTERSECT);
         end
         CMD_SPH_DIST: begin
            dist_v = sph_out_ff ? 32'sd0 : dsat;
         end
         CMD_BOX_ANY: begin
            flag_v = !box_out_ff;
         end
         CMD_BOX_CLS: begin
            cls_v = box_out_ff ? CLS_OUTSIDE :
                    ((full_ff == CW'(PLANE_COUNT)) ? CLS_INSIDE : CLS_INTERSECT);
         end
         default: begin
            cls_v = CLS_OUTSIDE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               cnt_in = '0;
            end
         end
         ST_RUN: begin
            if (issue) cnt_in = cnt_ff + CW'(1);
            else if (!v1_ff && !v2_ff && !v3_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (fire) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_item.command == CMD_LOAD)) begin
         store_ff[q_item.plane_index[PIW-1:0]][q_item.coefficient_index] <=
            q_item.coefficient_value;
      end
      if (start) begin
         cmd_ff <= q_item.command;
         rad_ff <= q_item.sphere_radius;
         crd_ff[0] <= sat_c(EW'(q_item.center_x) -
                            (is_box ? $signed(EW'(q_item.half_x)) : EW'(0)));
         crd_ff[1] <= sat_c(EW'(q_item.center_x) +
                            (is_box ? $signed(EW'(q_item.half_x)) : EW'(0)));
         crd_ff[2] <= sat_c(EW'(q_item.center_y) -
                            (is_box ? $signed(EW'(q_item.half_y)) : EW'(0)));
         crd_ff[3] <= sat_c(EW'(q_item.center_y) +
                            (is_box ? $signed(EW'(q_item.half_y)) : EW'(0)));
         crd_ff[4] <= sat_c(EW'(q_item.center_z) -
                            (is_box ? $signed(EW'(q_item.half_z)) : EW'(0)));
         crd_ff[5] <= sat_c(EW'(q_item.center_z) +
                            (is_box ? $signed(EW'(q_item.half_z)) : EW'(0)));
         any_neg_ff <= 1'b0;
         sph_out_ff <= 1'b0;
         box_out_ff <= 1'b0;
         above_ff <= '0;
         full_ff <= '0;
         last_d_ff <= '0;
      end
      for (int k = 0; k < 6; k++) begin
         prod_ff[k] <= $signed(store_ff[ridx][k/2]) * crd_ff[k];
         t_ff[k] <= term(prod_ff[k]);
      end
      d1_ff <= store_ff[ridx][3];
      d2_ff <= d1_ff;
      for (int k = 0; k < 8; k++) begin
         s_ff[k] <= t_ff[k & 1] + t_ff[2 + ((k >> 1) & 1)] + t_ff[4 + ((k >> 2) & 1)] +
                    64'(d2_ff);
      end
      if (v3_ff) begin
         if (d0 < 64'sd0) any_neg_ff <= 1'b1;
         if (d0 < -rr) sph_out_ff <= 1'b1;
         if (d0 > rr) above_ff <= above_ff + CW'(1);
         last_d_ff <= d0;
         if (npos == 4'd0) box_out_ff <= 1'b1;
         if (npos == 4'd8) full_ff <= full_ff + CW'(1);
      end
      if (fire) begin
         cls_ff <= cls_v;
         flag_ff <= flag_v;
         dist_ff <= dist_v;
      end
   end

endmodule

>>> hw/rtl/frustum_cull_test_unit.sv
// Frustum cull test unit top level: stream ports, request queue front end and plane back end.
// Depends on fcull_pkg, fcull_front, fcull_back.
//
// Usage: requests enter on req_ (tuser carries the command). Load requests
// write one plane coefficient and give no response; commands 6 and 7 and
// loads to an absent plane are dropped. Every other request gives one
// response on rsp_ with classification, inside flag and distance.
// Timing: a two-entry request queue feeds a back end that runs one plane
// per cycle, all box corners at once, through a distance pipeline of
// product, term and sum registers into the response register; a load is
// written as it is popped, and queries are worked one at a time.
// Reset clears the queue, the sequencer and the response valid; plane
// coefficients hold garbage until loaded. When the receiver stalls, the
// response holds, the back end waits with its next result and the queue
// fills, after which req_tready drops.
module frustum_cull_test_unit
   import fcull_pkg::*;
#(
   parameter int PLANE_COUNT = 6,
   parameter int COORD_BITS  = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // plane_index, coefficient_index, coefficient_value, center_x, center_y,
   // center_z, sphere_radius, half_x, half_y, half_z, zero pad
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // command
   input  logic [2:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // classification, inside_flag, distance, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   item_type           in_item, q_item;
   logic               q_valid, q_pop;
   logic [1:0]         cls;
   logic               flag;
   logic signed [31:0] distance;

   always_comb begin
      in_item.command           = req_tuser;
      in_item.plane_index       = req_tdata[2:0];
      in_item.coefficient_index = req_tdata[4:3];
      in_item.coefficient_value = req_tdata[36:5];
      in_item.center_x          = req_tdata[68:37];
      in_item.center_y          = req_tdata[100:69];
      in_item.center_z          = req_tdata[132:101];
      in_item.sphere_radius     = req_tdata[163:133];
      in_item.half_x            = req_tdata[194:164];
      in_item.half_y            = req_tdata[225:195];
      in_item.half_z            = req_tdata[256:226];
   end

   assign rsp_tdata = {5'd0, distance, flag, cls};

   fcull_front #(.PLANE_COUNT(PLANE_COUNT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   fcull_back #(
      .PLANE_COUNT (PLANE_COUNT),
      .COORD_BITS  (COORD_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_classification (cls),
      .rsp_inside_flag    (flag),
      .rsp_distance       (distance)
   );

endmodule

>>> hw/rtl/fcull_checker.sv
// Frustum cull port checker and its bind to the top level.
// Depends on fcull_pkg and frustum_cull_test_unit.
module fcull_checker
   import fcull_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_fields_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[39:35] == 5'd0)
      else $error("bad classification or pad bits");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[1:0] != CLS_OUTSIDE) &&
                     (rsp_tdata[34:3] == 32'd0 ||
                      (!rsp_tdata[2] && rsp_tdata[1:0] == CLS_OUTSIDE)))
      else $error("response mixes result kinds");

endmodule

bind frustum_cull_test_unit fcull_checker u_fcull_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/frustum_cull_test_unit_test.sv
// Testbench for frustum_cull_test_unit: loads frustum planes, then checks point, sphere and
// box queries against a fixed-point predictor held in a scoreboard class.
// Depends on fcull_pkg and frustum_cull_test_unit.
`timescale 1ns / 100ps

module frustum_cull_test_unit_test;
   import fcull_pkg::*;

   localparam int PLANES    = 6;
   localparam int FRAC      = 16;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic [1:0]         cls;
      logic               flag;
      logic signed [31:0] dist_val;
   } cull_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [2:0]               req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int errors = 0;
   int cycles = 0;
   int n_queries = 0;
   int n_results = 0;

   always #4 clock = ~clock;

   frustum_cull_test_unit u_top (.*);

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   class cull_scoreboard;
      logic signed [31:0] planes [PLANES][4];
      cull_result_type    pending [$];

      function automatic logic signed [63:0] term(logic signed [31:0] a, logic signed [63:0] b);
         logic signed [127:0] prod;
         logic signed [127:0] q;
         prod = 128'(a) * 128'(b);
         q = prod >>> FRAC;
         if (q > 128'sh2000000000000000) q = 128'sh2000000000000000;
         if (q < -128'sh2000000000000000) q = -128'sh2000000000000000;
         return q[63:0];
      endfunction

      function automatic logic signed [63:0] sat32(logic signed [63:0] v);
         if (v > 64'sh7fffffff) return 64'sh7fffffff;
         if (v < -64'sh80000000) return -64'sh80000000;
         return v;
      endfunction

      function automatic logic signed [63:0] plane_dist(int p, logic signed [63:0] x,
                                                        logic signed [63:0] y,
                                                        logic signed [63:0] z);
         return term(planes[p][0], sat32(x)) + term(planes[p][1], sat32(y))
              + term(planes[p][2], sat32(z)) + 64'(planes[p][3]);
      endfunction

      function automatic int corners_above(int p, item_type it);
         int n;
         logic signed [63:0] x, y, z;
         n = 0;
         for (int k = 0; k < 8; k++) begin
            x = k[0] ? 64'(it.center_x) + it.half_x : 64'(it.center_x) - it.half_x;
            y = k[1] ? 64'(it.center_y) + it.half_y : 64'(it.center_y) - it.half_y;
            z = k[2] ? 64'(it.center_z) + it.half_z : 64'(it.center_z) - it.half_z;
            if (plane_dist(p, x, y, z) > 0) n++;
         end
         return n;
      endfunction

      function automatic void note_request(item_type it);
         cull_result_type res;
         logic signed [63:0] d, r;
         int above, n;
         bit outside;
         res = '0;
         r = 64'(it.sphere_radius);
         case (it.command)
            CMD_LOAD: begin
               if (it.plane_index < PLANES)
                  planes[it.plane_index][it.coefficient_index] = it.coefficient_value;
               return;
            end
            CMD_POINT: begin
               res.flag = 1'b1;
               for (int p = 0; p < PLANES; p++)
                  if (plane_dist(p, it.center_x, it.center_y, it.center_z) < 0) res.flag = 1'b0;
            end
            CMD_SPH_CLS, CMD_SPH_DIST: begin
               above = 0;
               outside = 0;
               d = 0;
               for (int p = 0; p < PLANES && !outside; p++) begin
                  d = plane_dist(p, it.center_x, it.center_y, it.center_z);
                  if (d < -r) outside = 1;
                  else if (d > r) above++;
               end
               if (it.command == CMD_SPH_CLS)
                  res.cls = outside ? CLS_OUTSIDE : (above == PLANES ? CLS_INSIDE : CLS_INTERSECT);
               else if (!outside)
                  res.dist_val = 32'(sat32(d + r));
            end
            CMD_BOX_ANY: begin
               res.flag = 1'b1;
               for (int p = 0; p < PLANES; p++)
                  if (corners_above(p, it) == 0) res.flag = 1'b0;
            end
            CMD_BOX_CLS: begin
               above = 0;
               outside = 0;
               for (int p = 0; p < PLANES && !outside; p++) begin
                  n = corners_above(p, it);
                  if (n == 0) outside = 1;
                  else if (n == 8) above++;
               end
               res.cls = outside ? CLS_OUTSIDE : (above == PLANES ? CLS_INSIDE : CLS_INTERSECT);
            end
            default: return;
         endcase
         pending.push_back(res);
      endfunction

      task automatic check_result(logic [RSP_DATA_BITS-1:0] data);
         cull_result_type want, got;
         got.cls      = data[1:0];
         got.flag     = data[2];
         got.dist_val = data[34:3];
         if (pending.size() == 0) begin
            report("unexpected response", 64'(data), 64'd0);
            return;
         end
         want = pending.pop_front();
         if (got.cls !== want.cls) report("classification", 64'(got.cls), 64'(want.cls));
         if (got.flag !== want.flag) report("inside_flag", 64'(got.flag), 64'(want.flag));
         if (got.dist_val !== want.dist_val)
            report("distance", 64'(got.dist_val), 64'(want.dist_val));
      endtask
   endclass

   cull_scoreboard sb = new();

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'(int'($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(item_type it);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= it.command;
      req_tdata  <= {7'd0, it.half_z, it.half_y, it.half_x, it.sphere_radius,
                     it.center_z, it.center_y, it.center_x, it.coefficient_value,
                     it.coefficient_index, it.plane_index};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(it);
      if (it.command inside {CMD_POINT, CMD_SPH_CLS, CMD_SPH_DIST, CMD_BOX_ANY, CMD_BOX_CLS})
         n_queries++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic load_coef(int p, int c, logic [31:0] v);
      item_type it;
      it = '0;
      it.command = CMD_LOAD;
      it.plane_index = 3'(p);
      it.coefficient_index = 2'(c);
      it.coefficient_value = v;
      send_request(it);
   endtask

   function automatic item_type rand_query(logic [2:0] cmd, bit wide);
      item_type it;
      it = '0;
      it.command = cmd;
      it.plane_index = 3'($urandom());
      it.coefficient_index = 2'($urandom());
      it.coefficient_value = $urandom();
      it.center_x = wide ? rand_word() : 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      it.center_y = wide ? rand_word() : 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      it.center_z = wide ? rand_word() : 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      it.sphere_radius = wide ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
      it.half_x = wide ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
      it.half_y = wide ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
      it.half_z = wide ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
      return it;
   endfunction

   // receiver with random stalls
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata);
         n_results++;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      item_type it;
      logic [2:0] cmd;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // cube frustum: a=+-1, |coord| <= 100
      for (int p = 0; p < PLANES; p++)
         for (int c = 0; c < 4; c++)
            load_coef(p, c, c == 3 ? 32'(100 << FRAC) :
                      (c == p / 2 ? ((p % 2) ? -32'sd65536 : 32'sd65536) : 32'sd0));
      load_coef(7, 0, 32'hffffffff);
      for (int k = 1; k <= 5; k++) begin
         it = rand_query(3'(k), 0);
         it.center_x = 0; it.center_y = 0; it.center_z = 0;
         send_request(it);
      end
      it = rand_query(CMD_SPH_DIST, 0);
      it.center_x = 32'h7fffffff; it.center_y = 32'h80000000; it.center_z = 32'h7fffffff;
      it.sphere_radius = '1;
      send_request(it);
      it = rand_query(CMD_BOX_CLS, 0);
      it.center_x = 32'h80000000; it.half_x = '1; it.half_y = '1; it.half_z = '1;
      send_request(it);
      it = rand_query(3'd6, 1);
      send_request(it);
      it = rand_query(3'd7, 1);
      send_request(it);
      it = rand_query(CMD_POINT, 0);
      it.center_x = 32'(100 << FRAC);
      send_request(it);

      // extreme coefficients
      for (int c = 0; c < 4; c++) load_coef(0, c, c[0] ? 32'h80000000 : 32'h7fffffff);
      for (int k = 1; k <= 5; k++) send_request(rand_query(3'(k), 1));

      drain();
      for (int i = 0; i < 800; i++) begin
         if ($urandom_range(0, 9) == 0)
            load_coef($urandom_range(0, 7), $urandom_range(0, 3), rand_word());
         else begin
            cmd = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7)) :
                  3'($urandom_range(1, 5));
            send_request(rand_query(cmd, $urandom_range(0, 4) == 0));
         end
         if (i == 400) drain();
      end

      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d queries with %0d responses over loads, drops and random stalls",
               n_queries, n_results);
      if (errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
